/* hdl/etmb_pkg.sv */
package etmb_pkg;

  // Bank size and field widths.
  localparam int NUM_METERS = 128;
  localparam int TIME_BITS  = 32;
  localparam int COUNT_W    = 32;
  localparam int MNUM_W     = 8;
  localparam int IDX_W      = $clog2(NUM_METERS);
  localparam int CNT_W      = $clog2(NUM_METERS + 1);

  // Command codes.
  localparam logic [2:0] CMD_CREATE     = 3'd0;
  localparam logic [2:0] CMD_RESET      = 3'd1;
  localparam logic [2:0] CMD_TICK       = 3'd2;
  localparam logic [2:0] CMD_START      = 3'd3;
  localparam logic [2:0] CMD_STOP       = 3'd4;
  localparam logic [2:0] CMD_READ       = 3'd5;
  localparam logic [2:0] CMD_READ_CLEAR = 3'd6;
  localparam logic [2:0] CMD_CLEAR_ALL  = 3'd7;

  // Status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_METER    = 2'd1;
  localparam logic [1:0] ST_NOT_RUNNING = 2'd2;
  localparam logic [1:0] ST_FULL        = 2'd3;

  typedef struct packed {
    logic [2:0]           command;
    logic [MNUM_W-1:0]    meter_number;
    logic [TIME_BITS-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [MNUM_W-1:0]    result_meter;
    logic [COUNT_W-1:0]   enter_count;
    logic [TIME_BITS-1:0] total_time;
    logic                 was_running;
  } res_t;

  // One meter as held in the entry memory.
  typedef struct packed {
    logic [TIME_BITS-1:0] start_stamp;
    logic                 running;
    logic [TIME_BITS-1:0] time_total;
    logic [COUNT_W-1:0]   entry_count;
  } entry_t;

  // Command as it enters the update stage, with the checks done at issue.
  typedef struct packed {
    logic [2:0]           command;
    logic [IDX_W-1:0]     idx;
    logic [MNUM_W-1:0]    meter;
    logic [TIME_BITS-1:0] now;
    logic [1:0]           pre_status;
  } exec_t;

endpackage

/* hdl/event_time_meter_bank_unit.sv */
// A word accepted at a clock edge is registered into the update stage while its entry is
// read; its result word is then registered onto res_o and marked by done_o.
// Throughput: one word per cycle; busy is never raised. The entry memory is read at
// issue and written in the cycle after, and a write is forwarded to a following read.
// Reset clears the meter count and the pipeline control; meter entries are not cleared.
// The receiver cannot stall, so no result is ever held back.
module event_time_meter_bank_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  etmb_pkg::cmd_t   cmd_i,
  output logic             done_o,
  output etmb_pkg::res_t   res_o
);
  import etmb_pkg::*;

  // Issue stage. The range checks and the meter count live here, so every
  // command sees the count left by the command right before it.
  logic             accept;
  logic [CNT_W-1:0] miu_q, miu_d;
  logic             full;
  logic             out_of_range;
  logic [MNUM_W-1:0] num_m1;
  exec_t            ex_d, ex_q;
  logic             ex_valid_q;

  // Update stage and forwarding.
  entry_t           rdata;
  entry_t           entry_cur;
  logic             we;
  entry_t           wdata;
  res_t             res_d, res_q;
  logic             done_q;
  logic             fwd_valid_q;
  logic [IDX_W-1:0] fwd_idx_q;
  entry_t           fwd_data_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full         = (miu_q == CNT_W'(NUM_METERS));
  assign out_of_range = (cmd_i.meter_number == '0) ||
                        (cmd_i.meter_number > MNUM_W'(miu_q));
  assign num_m1       = cmd_i.meter_number - MNUM_W'(1);

  always_comb begin
    ex_d.command    = cmd_i.command;
    ex_d.now        = cmd_i.now;
    ex_d.idx        = num_m1[IDX_W-1:0];
    ex_d.meter      = cmd_i.meter_number;
    ex_d.pre_status = ST_OK;
    miu_d           = miu_q;
    case (cmd_i.command)
      CMD_CLEAR_ALL: begin
        miu_d = '0;
      end
      CMD_CREATE: begin
        // The new meter takes the next free slot; its number is the new count.
        ex_d.idx   = miu_q[IDX_W-1:0];
        ex_d.meter = MNUM_W'(miu_q + CNT_W'(1));
        if (full) begin
          ex_d.pre_status = ST_FULL;
        end else begin
          miu_d = miu_q + CNT_W'(1);
        end
      end
      default: begin
        if (out_of_range) begin
          ex_d.pre_status = ST_NO_METER;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miu_q      <= '0;
      ex_valid_q <= 1'b0;
    end else begin
      ex_valid_q <= accept;
      if (accept) begin
        miu_q <= miu_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_q <= ex_d;
    end
  end

  // The memory is read with the issue-stage index at the accepting edge.
  etmb_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we && ex_valid_q),
    .waddr_i (ex_q.idx),
    .wdata_i (wdata),
    .raddr_i (ex_d.idx),
    .rdata_o (rdata)
  );

  // A write committed at the same edge as this entry's read is not in the
  // read data yet, so it is taken from the forwarding register instead.
  assign entry_cur = (fwd_valid_q && (fwd_idx_q == ex_q.idx)) ? fwd_data_q : rdata;

  etmb_exec u_exec (
    .ex_i    (ex_q),
    .entry_i (entry_cur),
    .we_o    (we),
    .wdata_o (wdata),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      fwd_valid_q <= we && ex_valid_q;
      done_q      <= ex_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_idx_q  <= ex_q.idx;
    fwd_data_q <= wdata;
    res_q      <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef NO_ASSERTIONS
  // Every accepted word produces a result strobe on done_o.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("result strobe missing after an accepted word");

  // No result strobe without a word in the update stage in the cycle before.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(ex_valid_q))
    else $error("result strobe without a command");

  // The meter count never exceeds the bank size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    miu_q <= CNT_W'(NUM_METERS))
    else $error("meter count beyond bank size");

  // A failed command reports nothing but its status.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status != ST_OK)) |->
      (res_o.result_meter == '0 && res_o.enter_count == '0 &&
       res_o.total_time == '0 && !res_o.was_running))
    else $error("failed command returned data");
`endif

endmodule

/* hdl/etmb_mem.sv */
module etmb_mem (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [etmb_pkg::IDX_W-1:0] waddr_i,
  input  etmb_pkg::entry_t        wdata_i,
  input  logic [etmb_pkg::IDX_W-1:0] raddr_i,
  output etmb_pkg::entry_t        rdata_o
);
  import etmb_pkg::*;

  entry_t mem_q [NUM_METERS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/etmb_exec.sv */
module etmb_exec (
  input  etmb_pkg::exec_t  ex_i,
  input  etmb_pkg::entry_t entry_i,
  output logic             we_o,
  output etmb_pkg::entry_t wdata_o,
  output etmb_pkg::res_t   res_o
);
  import etmb_pkg::*;

  logic [TIME_BITS-1:0] elapsed;
  logic [COUNT_W-1:0]   count_inc;

  assign elapsed   = ex_i.now - entry_i.start_stamp;
  assign count_inc = entry_i.entry_count + COUNT_W'(1);

  always_comb begin
    we_o    = 1'b0;
    wdata_o = entry_i;
    res_o   = '0;
    if (ex_i.pre_status != ST_OK) begin
      res_o.status = ex_i.pre_status;
    end else begin
      res_o.status       = ST_OK;
      res_o.result_meter = ex_i.meter;
      res_o.enter_count  = entry_i.entry_count;
      res_o.total_time   = entry_i.time_total;
      case (ex_i.command)
        CMD_CREATE, CMD_RESET: begin
          we_o               = 1'b1;
          wdata_o            = '0;
          res_o.enter_count  = '0;
          res_o.total_time   = '0;
        end
        CMD_TICK: begin
          we_o                = 1'b1;
          wdata_o.entry_count = count_inc;
          res_o.enter_count   = count_inc;
        end
        CMD_START: begin
          we_o                = 1'b1;
          wdata_o.start_stamp = ex_i.now;
          wdata_o.running     = 1'b1;
        end
        CMD_STOP: begin
          if (!entry_i.running) begin
            res_o        = '0;
            res_o.status = ST_NOT_RUNNING;
          end else begin
            we_o                = 1'b1;
            wdata_o.time_total  = entry_i.time_total + elapsed;
            wdata_o.start_stamp = '0;
            wdata_o.running     = 1'b0;
            wdata_o.entry_count = count_inc;
            res_o.enter_count   = count_inc;
            res_o.total_time    = entry_i.time_total + elapsed;
          end
        end
        CMD_READ: begin
          res_o.was_running = entry_i.running;
        end
        CMD_READ_CLEAR: begin
          we_o                = 1'b1;
          wdata_o.entry_count = '0;
          wdata_o.time_total  = '0;
          res_o.was_running   = entry_i.running;
        end
        CMD_CLEAR_ALL: begin
          res_o = '0;
        end
        default: begin
          res_o = '0;
        end
      endcase
    end
  end

endmodule
